>>> sv/calibrated_valley_peak_counter_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CALIBRATED_VALLEY_PEAK_COUNTER_CORE_DEFINES_SVH
`define CALIBRATED_VALLEY_PEAK_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CVPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CVPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/cvpc_pkg.sv
// Types and constants of the calibrated valley and peak counter.
package cvpc_pkg;

   localparam int SAMPLE_W = 8;
   localparam int PHASE_W  = 12;
   localparam int COUNT_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [PHASE_W-1:0]  CAL_LENGTH_RESET = 12'd100;
   localparam logic [COUNT_W-1:0]  MIN_RUN_RESET    = 8'd10;
   localparam logic [SAMPLE_W-1:0] PEAK_FLOOR_RESET = 8'd30;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX       = 8'd255;
   localparam logic [COUNT_W-1:0]  RUN_MAX          = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_LENGTH = 2'd0,
      CSR_MIN_RUN    = 2'd1,
      CSR_PEAK_FLOOR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  calibrate_length;
      logic [COUNT_W-1:0]  min_run;
      logic [SAMPLE_W-1:0] peak_floor;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase_count;
      logic [SAMPLE_W-1:0] window_min;
      logic [SAMPLE_W-1:0] window_max;
      logic [SAMPLE_W-1:0] valley_value;
      logic [COUNT_W-1:0]  valley_run;
      logic [COUNT_W-1:0]  peak_count;
   } state_type;

   typedef struct packed {
      logic                calibrating;
      logic                peak_seen;
      logic [COUNT_W-1:0]  peak_total;
      logic [SAMPLE_W-1:0] cal_min;
      logic [SAMPLE_W-1:0] cal_max;
      logic                window_done;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      calibrate_length: CAL_LENGTH_RESET,
      min_run:          MIN_RUN_RESET,
      peak_floor:       PEAK_FLOOR_RESET
   };

   localparam state_type STATE_CLEAR = '{
      phase_count:  '0,
      window_min:   SAMPLE_MAX,
      window_max:   '0,
      valley_value: '0,
      valley_run:   '0,
      peak_count:   '0
   };

endpackage

>>> sv/cvpc_if.sv
// Request and response channel interfaces.
interface cvpc_req_if import cvpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface cvpc_rsp_if import cvpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                calibrating;
   logic                peak_seen;
   logic [COUNT_W-1:0]  peak_total;
   logic [SAMPLE_W-1:0] cal_min;
   logic [SAMPLE_W-1:0] cal_max;
   logic                window_done;

   modport source (output valid, output calibrating, output peak_seen, output peak_total,
                   output cal_min, output cal_max, output window_done, input ready);
   modport sink   (input valid, input calibrating, input peak_seen, input peak_total,
                   input cal_min, input cal_max, input window_done, output ready);
endinterface

>>> sv/cvpc_update.sv
// Per-sample update of window state and result fields.
module cvpc_update import cvpc_pkg::*; (
   input  state_type           st,
   input  cfg_type             cfg,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic                last,
   output state_type           st_next,
   output result_type          res
);

   state_type           nxt;
   logic                cal;
   logic                peak;
   logic [SAMPLE_W-1:0] valley;

   always_comb begin
      nxt    = st;
      peak   = 1'b0;
      cal    = st.phase_count < cfg.calibrate_length;
      valley = (st.valley_run == '0) ? sample : st.valley_value;
      if (cal) begin
         if (sample > st.window_max) begin
            nxt.window_max = sample;
         end
         if (sample < st.window_min) begin
            nxt.window_min = sample;
         end
         nxt.valley_value = nxt.window_max;
         nxt.phase_count  = st.phase_count + PHASE_W'(1);
      end else if (sample > st.window_min) begin
         if (st.valley_run >= cfg.min_run && sample > cfg.peak_floor) begin
            peak             = 1'b1;
            nxt.peak_count   = st.peak_count + COUNT_W'(1);
            nxt.valley_run   = '0;
            nxt.valley_value = st.window_max;
         end
      end else begin
         nxt.valley_value = valley;
         if (sample == valley && st.valley_run != RUN_MAX) begin
            nxt.valley_run = st.valley_run + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      res.calibrating = cal;
      res.peak_seen   = peak;
      res.peak_total  = nxt.peak_count;
      res.cal_min     = nxt.window_min;
      res.cal_max     = nxt.window_max;
      res.window_done = last;
      st_next         = last ? STATE_CLEAR : nxt;
   end

endmodule

>>> sv/calibrated_valley_peak_counter_core.sv
// Calibrated valley and peak counter: one 8-bit sample per item, one result per item.
// Throughput is one item per clock unless the response side stalls. Window state and
// the registered result update together at the edge that accepts an item, and a new item
// is taken whenever the result register is empty or its item leaves in the same cycle.
// Configuration writes take effect on the next accepted item and survive window ends.
module calibrated_valley_peak_counter_core import cvpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cvpc_req_if.sink              req_if,
   cvpc_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  st_ff;
   state_type  st_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       req_take;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   cvpc_update u_update (
      .st      (st_ff),
      .cfg     (cfg_ff),
      .sample  (req_if.sample),
      .last    (req_if.last),
      .st_next (st_in),
      .res     (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAL_LENGTH: cfg_in.calibrate_length = csr_wdata[PHASE_W-1:0];
            CSR_MIN_RUN:    cfg_in.min_run          = csr_wdata[COUNT_W-1:0];
            CSR_PEAK_FLOOR: cfg_in.peak_floor       = csr_wdata[SAMPLE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         st_ff        <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_take) begin
            st_ff        <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.calibrating = rsp_ff.calibrating;
   assign rsp_if.peak_seen   = rsp_ff.peak_seen;
   assign rsp_if.peak_total  = rsp_ff.peak_total;
   assign rsp_if.cal_min     = rsp_ff.cal_min;
   assign rsp_if.cal_max     = rsp_ff.cal_max;
   assign rsp_if.window_done = rsp_ff.window_done;

endmodule

>>> sv/cvpc_checker.sv
// Port-level checker for the counter core and its bind.
`include "calibrated_valley_peak_counter_core_defines.svh"

module cvpc_checker import cvpc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                calibrating,
   input logic                peak_seen,
   input logic [COUNT_W-1:0]  peak_total,
   input logic [SAMPLE_W-1:0] cal_min,
   input logic [SAMPLE_W-1:0] cal_max,
   input logic                window_done
);

   `CVPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(peak_total) && $stable(cal_min) && $stable(cal_max) && $stable(window_done), "stalled item changed")
   `CVPC_ASSERT_NOW(a_peak_not_cal, clock, reset, rsp_valid && peak_seen, !calibrating, "peak during calibration")
   `CVPC_ASSERT_NOW(a_cal_order, clock, reset, rsp_valid && calibrating, cal_min <= cal_max, "minimum above maximum")
   `CVPC_ASSERT_NOW(a_peak_min, clock, reset, rsp_valid && peak_seen, cal_min != SAMPLE_MAX, "peak with empty calibration")

endmodule

bind calibrated_valley_peak_counter_core cvpc_checker u_cvpc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .calibrating (rsp_if.calibrating),
   .peak_seen   (rsp_if.peak_seen),
   .peak_total  (rsp_if.peak_total),
   .cal_min     (rsp_if.cal_min),
   .cal_max     (rsp_if.cal_max),
   .window_done (rsp_if.window_done)
);
